// ----- hw/rtl/mvtg_pkg.sv -----
package mvtg_pkg;

    // Default build values
    localparam int VOICES_DEF    = 8;
    localparam int MIX_SHIFT_DEF = 3;

    // Request operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_MUTE  = 2'd2;

    // Per-voice register selects
    localparam logic [2:0] REG_STEP_LO   = 3'd0;
    localparam logic [2:0] REG_STEP_HI   = 3'd1;
    localparam logic [2:0] REG_LVOL_HOLD = 3'd2;
    localparam logic [2:0] REG_VOLUME    = 3'd3;
    localparam logic [2:0] REG_SHAPE     = 3'd5;

    // Wave value and product widths
    localparam int WAVE_W = 16;
    localparam int PROD_W = 25;

    // One voice entry of the state memory
    typedef struct packed {
        logic [7:0]  step_lo;
        logic [15:0] step;
        logic [7:0]  lvol_hold;
        logic [7:0]  lvol;
        logic [7:0]  rvol;
        logic [15:0] phase;
        logic [2:0]  shape;
    } t_voice;

    // Marker that travels with each voice through the tick pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_beat;

endpackage

// ----- hw/rtl/mvtg_voice_mem.sv -----
module mvtg_voice_mem #(
    parameter int VOICES = mvtg_pkg::VOICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clr,
    input  logic                                i_rd_en,
    input  logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] i_rd_idx,
    output mvtg_pkg::t_voice                    o_rd_data,
    input  logic                                i_wr_en,
    input  logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] i_wr_idx,
    input  mvtg_pkg::t_voice                    i_wr_data
);

    mvtg_pkg::t_voice r_mem [VOICES];
    mvtg_pkg::t_voice r_rd_data;
    logic [VOICES-1:0] r_vld;
    logic              r_rd_vld;

    // Storage array, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Entry valid bits: reset and mute make every entry read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- hw/rtl/mvtg_voice_step.sv -----
module mvtg_voice_step #(
    parameter int VOICES = mvtg_pkg::VOICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mvtg_pkg::t_beat                     i_beat,
    input  logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] i_idx,
    input  mvtg_pkg::t_voice                    i_voice,
    output logic                                o_wr_en,
    output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] o_wr_idx,
    output mvtg_pkg::t_voice                    o_wr_data,
    output mvtg_pkg::t_beat                     o_beat,
    output logic signed [mvtg_pkg::WAVE_W-1:0]  o_wave,
    output logic [7:0]                          o_lvol,
    output logic [7:0]                          o_rvol
);

    localparam logic signed [15:0] LEVEL_HI = 16'sh2000;
    localparam logic signed [15:0] LEVEL_LO = 16'she000;

    logic [16:0]                        r_noise;
    mvtg_pkg::t_beat                    r_beat;
    logic signed [mvtg_pkg::WAVE_W-1:0] r_wave;
    logic [7:0]                         r_lvol;
    logic [7:0]                         r_rvol;

    logic        active;
    logic        is_noise;
    logic [15:0] new_phase;
    logic [16:0] n_noise;
    logic signed [mvtg_pkg::WAVE_W-1:0] n_wave;

    // Wave shape from the stepped phase
    function automatic logic signed [15:0] wave_of(input logic [2:0] sh, input logic [15:0] p);
        logic [14:0]        u;
        logic signed [16:0] d;
        logic signed [15:0] w;
        u = p[14] ? ~{p[13:0], 1'b0} : {p[13:0], 1'b0};
        d = '0;
        case (sh)
            3'd0: w = p[15] ? LEVEL_LO : LEVEL_HI;
            3'd1: w = (p[15] | p[14]) ? LEVEL_LO : LEVEL_HI;
            3'd2: w = (p[15] | p[14] | p[13]) ? LEVEL_LO : LEVEL_HI;
            3'd3: w = (p[15] & p[14]) ? LEVEL_LO : LEVEL_HI;
            3'd4: w = p[15] ? -$signed({1'b0, u}) : $signed({1'b0, u});
            3'd5: begin
                d = 17'sh07fff - $signed({1'b0, p});
                w = 16'(d >>> 1);
            end
            3'd6: w = p[15] ? $signed({1'b0, u}) : -$signed({1'b0, u});
            default: begin
                d = $signed({1'b0, p}) - 17'sh07fff;
                w = 16'(d >>> 1);
            end
        endcase
        return w;
    endfunction

    // Phase advance or noise clock for the voice just read
    always_comb begin
        active    = (i_voice.lvol != 8'd0) || (i_voice.rvol != 8'd0);
        is_noise  = (i_voice.step[15:8] == 8'hff);
        new_phase = i_voice.phase + i_voice.step;
        n_noise   = {r_noise[2] ^ r_noise[3], r_noise[16:1]};
        o_wr_data = i_voice;
        if (active && !is_noise) begin
            o_wr_data.phase = new_phase;
        end
        if (is_noise) begin
            n_wave = n_noise[0] ? LEVEL_LO : LEVEL_HI;
        end else begin
            n_wave = wave_of(i_voice.shape, new_phase);
        end
    end

    assign o_wr_en  = i_beat.vld;
    assign o_wr_idx = i_idx;

    // Shared noise register, clocked once per active noise voice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= 17'd1;
            r_beat  <= '0;
        end else begin
            if (i_beat.vld && active && is_noise) begin
                r_noise <= n_noise;
            end
            r_beat <= i_beat;
        end
    end

    // Wave value and volumes toward the mixer
    always_ff @(posedge i_clk) begin
        r_wave <= n_wave;
        r_lvol <= i_voice.lvol;
        r_rvol <= i_voice.rvol;
    end

    assign o_beat = r_beat;
    assign o_wave = r_wave;
    assign o_lvol = r_lvol;
    assign o_rvol = r_rvol;

endmodule

// ----- hw/rtl/mvtg_mixer.sv -----
module mvtg_mixer #(
    parameter int VOICES    = mvtg_pkg::VOICES_DEF,
    parameter int MIX_SHIFT = mvtg_pkg::MIX_SHIFT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mvtg_pkg::t_beat                    i_beat,
    input  logic signed [mvtg_pkg::WAVE_W-1:0] i_wave,
    input  logic [7:0]                         i_lvol,
    input  logic [7:0]                         i_rvol,
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic signed [15:0]                 o_left,
    output logic signed [15:0]                 o_right,
    output logic                               o_lclip,
    output logic                               o_rclip,
    output logic                               o_busy
);

    localparam int SUM_W = mvtg_pkg::PROD_W + $clog2(VOICES);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sd32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32'sd32768);

    mvtg_pkg::t_beat                    r_p_beat;
    logic signed [mvtg_pkg::PROD_W-1:0] r_pl;
    logic signed [mvtg_pkg::PROD_W-1:0] r_pr;
    logic signed [SUM_W-1:0]            r_acc_l;
    logic signed [SUM_W-1:0]            r_acc_r;
    logic                               r_fin;
    logic                               r_o_valid;
    logic signed [15:0]                 r_left;
    logic signed [15:0]                 r_right;
    logic                               r_lclip;
    logic                               r_rclip;

    logic signed [SUM_W-1:0] sh_l;
    logic signed [SUM_W-1:0] sh_r;
    logic                    load;

    // Weight by the volumes
    always_ff @(posedge i_clk) begin
        r_pl <= i_wave * $signed({1'b0, i_lvol});
        r_pr <= i_wave * $signed({1'b0, i_rvol});
    end

    // Sum over the voices of one tick
    always_ff @(posedge i_clk) begin
        if (r_p_beat.vld) begin
            r_acc_l <= r_p_beat.first ? SUM_W'(r_pl) : r_acc_l + SUM_W'(r_pl);
            r_acc_r <= r_p_beat.first ? SUM_W'(r_pr) : r_acc_r + SUM_W'(r_pr);
        end
    end

    // Scale down; saturation follows in the output register
    always_comb begin
        sh_l = r_acc_l >>> MIX_SHIFT;
        sh_r = r_acc_r >>> MIX_SHIFT;
        load = r_fin && (!r_o_valid || i_ready);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left  <= (sh_l > SAT_HI) ? 16'sh7fff : (sh_l < SAT_LO) ? 16'sh8000 : sh_l[15:0];
            r_right <= (sh_r > SAT_HI) ? 16'sh7fff : (sh_r < SAT_LO) ? 16'sh8000 : sh_r[15:0];
            r_lclip <= (sh_l > SAT_HI) || (sh_l < SAT_LO);
            r_rclip <= (sh_r > SAT_HI) || (sh_r < SAT_LO);
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_beat  <= '0;
            r_fin     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_beat <= i_beat;
            if (r_p_beat.vld && r_p_beat.last) begin
                r_fin <= 1'b1;
            end else if (load) begin
                r_fin <= 1'b0;
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_lclip = r_lclip;
    assign o_rclip = r_rclip;
    assign o_busy  = i_beat.vld | r_p_beat.vld | r_fin;

endmodule

// ----- hw/rtl/multi_voice_tone_generator_top.sv -----
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   operation[1:0] address[9:2] data[17:10], zero pad to 24
// m_axis    out  left_sample[15:0] right_sample[31:16] left_clipped[32]
//                right_clipped[33], zero pad to 40
//
// A register write reads the entry, then writes it back; mute and unused codes finish on the accept.
// A sample tick reads one voice per cycle from the voice memory,
// then passes step, weight and sum stages ahead of the output reg.
// One request is in work at a time; a result waiting on m_axis does not block requests,
// but a following tick holds at its end until the output register is free.
// Synchronous active-low reset; voice entries read as zero after reset and after mute.
module multi_voice_tone_generator_top #(
    parameter int VOICES    = mvtg_pkg::VOICES_DEF,
    parameter int MIX_SHIFT = mvtg_pkg::MIX_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // operation, address, data
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // left, right, left_clipped, right_clipped
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [5:0]    VOICE_LIM  = 6'(VOICES);
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_TICK  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    logic [VW-1:0]   r_cnt;
    logic [VW-1:0]   r_idx;
    logic [2:0]      r_sel;
    logic [7:0]      r_data;
    mvtg_pkg::t_beat r_rd_beat;
    logic [VW-1:0]   r_rd_idx;

    logic [1:0]       in_op;
    logic [7:0]       in_addr;
    logic [7:0]       in_data;
    logic             accept;
    logic             in_range;
    logic             rd_en;
    logic [VW-1:0]    rd_idx;
    logic             mem_clr;
    mvtg_pkg::t_voice rd_voice;
    mvtg_pkg::t_voice upd_voice;
    logic             wr_en;
    logic [VW-1:0]    wr_idx;
    mvtg_pkg::t_voice wr_voice;
    logic             st_wr_en;
    logic [VW-1:0]    st_wr_idx;
    mvtg_pkg::t_voice st_wr_voice;
    mvtg_pkg::t_beat  st_beat;
    logic signed [mvtg_pkg::WAVE_W-1:0] st_wave;
    logic [7:0]       st_lvol;
    logic [7:0]       st_rvol;
    logic             mix_busy;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic             mix_lclip;
    logic             mix_rclip;

    // Request decode
    assign in_op    = i_s_axis_tdata[1:0];
    assign in_addr  = i_s_axis_tdata[9:2];
    assign in_data  = i_s_axis_tdata[17:10];
    assign in_range = ({1'b0, in_addr[7:3]} < VOICE_LIM);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign mem_clr  = accept && (in_op == mvtg_pkg::OP_MUTE);

    // Memory read port
    always_comb begin
        rd_en  = (r_state == S_TICK)
              || (accept && (in_op == mvtg_pkg::OP_WRITE) && in_range);
        rd_idx = (r_state == S_TICK) ? r_cnt : in_addr[3 +: VW];
    end

    // Register write, applied to the entry read the cycle before
    always_comb begin
        upd_voice = rd_voice;
        case (r_sel)
            mvtg_pkg::REG_STEP_LO:   upd_voice.step_lo = r_data;
            mvtg_pkg::REG_STEP_HI:   upd_voice.step = {r_data, rd_voice.step_lo};
            mvtg_pkg::REG_LVOL_HOLD: upd_voice.lvol_hold = r_data;
            mvtg_pkg::REG_VOLUME: begin
                upd_voice.lvol = rd_voice.lvol_hold;
                upd_voice.rvol = r_data;
                if ((rd_voice.lvol_hold == 8'd0) && (r_data == 8'd0)) begin
                    upd_voice.phase = 16'd0;
                end
            end
            mvtg_pkg::REG_SHAPE:     upd_voice.shape = r_data[2:0];
            default: ;
        endcase
    end

    // Memory write port
    always_comb begin
        if (r_state == S_WRITE) begin
            wr_en    = 1'b1;
            wr_idx   = r_idx;
            wr_voice = upd_voice;
        end else begin
            wr_en    = st_wr_en;
            wr_idx   = st_wr_idx;
            wr_voice = st_wr_voice;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (in_op == mvtg_pkg::OP_WRITE) && in_range) begin
                    n_state = S_WRITE;
                end else if (accept && (in_op == mvtg_pkg::OP_TICK)) begin
                    n_state = S_TICK;
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_TICK: begin
                if (r_cnt == LAST_VOICE) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_beat.vld && !st_beat.vld && !mix_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rd_beat <= '0;
        end else begin
            r_state       <= n_state;
            r_rd_beat.vld <= (r_state == S_TICK);
            r_rd_beat.first <= (r_cnt == '0);
            r_rd_beat.last  <= (r_cnt == LAST_VOICE);
            if (r_state == S_TICK) begin
                r_cnt <= (r_cnt == LAST_VOICE) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // Request and pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= in_addr[3 +: VW];
            r_sel  <= in_addr[2:0];
            r_data <= in_data;
        end
        r_rd_idx <= r_cnt;
    end

    mvtg_voice_mem #(
        .VOICES (VOICES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (mem_clr),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_voice),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_voice)
    );

    mvtg_voice_step #(
        .VOICES (VOICES)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (r_rd_beat),
        .i_idx     (r_rd_idx),
        .i_voice   (rd_voice),
        .o_wr_en   (st_wr_en),
        .o_wr_idx  (st_wr_idx),
        .o_wr_data (st_wr_voice),
        .o_beat    (st_beat),
        .o_wave    (st_wave),
        .o_lvol    (st_lvol),
        .o_rvol    (st_rvol)
    );

    mvtg_mixer #(
        .VOICES    (VOICES),
        .MIX_SHIFT (MIX_SHIFT)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (st_beat),
        .i_wave  (st_wave),
        .i_lvol  (st_lvol),
        .i_rvol  (st_rvol),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_left  (mix_left),
        .o_right (mix_right),
        .o_lclip (mix_lclip),
        .o_rclip (mix_rclip),
        .o_busy  (mix_busy)
    );

    assign o_m_axis_tdata = {6'd0, mix_rclip, mix_lclip, mix_right, mix_left};

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvtg_pkg::*;

    localparam int N_VOICES  = VOICES_DEF;
    localparam int PULSE_AMP = 32'sh2000;

    // Codes the package leaves unnamed
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] REG_SPARE0 = 3'd4;
    localparam logic [2:0] REG_SPARE1 = 3'd6;
    localparam logic [2:0] REG_SPARE2 = 3'd7;

    typedef enum logic [2:0] {
        WAVE_PULSE50, WAVE_PULSE25, WAVE_PULSE12, WAVE_PULSE75,
        WAVE_TRI, WAVE_SAW_DOWN, WAVE_TRI_INV, WAVE_SAW_UP
    } wave_e;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        left_clip;
        logic        right_clip;
    } mix_t;

    // Voice state mirror, mix prediction and result checking
    class tone_mix_scoreboard;
        logic [7:0]  step_lo_hold [N_VOICES];
        logic [15:0] step         [N_VOICES];
        logic [7:0]  lvol_hold    [N_VOICES];
        logic [7:0]  lvol         [N_VOICES];
        logic [7:0]  rvol         [N_VOICES];
        logic [15:0] phase        [N_VOICES];
        logic [2:0]  shape        [N_VOICES];
        logic [16:0] lfsr;
        mix_t        expected_mix_q[$];
        int          errors;

        function new();
            clear_voices();
            lfsr   = 17'd1;
            errors = 0;
        endfunction

        function void clear_voices();
            for (int v = 0; v < N_VOICES; v++) begin
                step_lo_hold[v] = '0;
                step[v]         = '0;
                lvol_hold[v]    = '0;
                lvol[v]         = '0;
                rvol[v]         = '0;
                phase[v]        = '0;
                shape[v]        = '0;
            end
        endfunction

        function int pending();
            return expected_mix_q.size();
        endfunction

        function int wave_of(logic [15:0] p, logic [2:0] sh);
            int u;
            int t;
            // triangle magnitude, folded in the second and fourth quarters
            u = (int'(p) << 1) & 'h7FFF;
            if (p[14]) u = 'h7FFF - u;
            case (wave_e'(sh))
                WAVE_PULSE50: t = p[15] ? -PULSE_AMP : PULSE_AMP;
                WAVE_PULSE25: t = (p[15:14] != 2'b00) ? -PULSE_AMP : PULSE_AMP;
                WAVE_PULSE12: t = (p[15:13] != 3'b000) ? -PULSE_AMP : PULSE_AMP;
                WAVE_PULSE75: t = (p[15:14] == 2'b11) ? -PULSE_AMP : PULSE_AMP;
                WAVE_TRI:     t = p[15] ? -u : u;
                WAVE_SAW_DOWN: t = (32'sh7FFF - int'(p)) >>> 1;
                WAVE_TRI_INV: t = p[15] ? u : -u;
                default:      t = (int'(p) - 32'sh7FFF) >>> 1;
            endcase
            return t;
        endfunction

        function logic [15:0] clamp16(longint s, output logic clip);
            clip = 1'b0;
            if (s < -32768) begin
                clip = 1'b1;
                return 16'h8000;
            end
            if (s > 32767) begin
                clip = 1'b1;
                return 16'h7FFF;
            end
            return s[15:0];
        endfunction

        // One tick: step every sounding voice and mix
        function mix_t predict_mix();
            longint sum_l;
            longint sum_r;
            int     t;
            mix_t   m;
            sum_l = 0;
            sum_r = 0;
            for (int v = 0; v < N_VOICES; v++) begin
                if (lvol[v] == 8'd0 && rvol[v] == 8'd0) continue;
                if (step[v][15:8] != 8'hFF) begin
                    phase[v] = phase[v] + step[v];
                    t = wave_of(phase[v], shape[v]);
                end else begin
                    // noise voice: shared LFSR, phase holds
                    lfsr = {lfsr[2] ^ lfsr[3], lfsr[16:1]};
                    t = lfsr[0] ? -PULSE_AMP : PULSE_AMP;
                end
                sum_l += longint'(t) * longint'(lvol[v]);
                sum_r += longint'(t) * longint'(rvol[v]);
            end
            sum_l = sum_l >>> MIX_SHIFT_DEF;
            sum_r = sum_r >>> MIX_SHIFT_DEF;
            m.left  = clamp16(sum_l, m.left_clip);
            m.right = clamp16(sum_r, m.right_clip);
            return m;
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] addr, logic [7:0] data);
            int v;
            v = addr[7:3];
            case (op)
                OP_WRITE: begin
                    if (v < N_VOICES) begin
                        case (addr[2:0])
                            REG_STEP_LO:   step_lo_hold[v] = data;
                            REG_STEP_HI:   step[v] = {data, step_lo_hold[v]};
                            REG_LVOL_HOLD: lvol_hold[v] = data;
                            REG_VOLUME: begin
                                lvol[v] = lvol_hold[v];
                                rvol[v] = data;
                                if (lvol[v] == 8'd0 && rvol[v] == 8'd0) phase[v] = '0;
                            end
                            REG_SHAPE:     shape[v] = data[2:0];
                            default: ;
                        endcase
                    end
                end
                OP_TICK: expected_mix_q.push_back(predict_mix());
                OP_MUTE: clear_voices();
                default: ;
            endcase
        endfunction

        function void check_mix(logic [39:0] tdata);
            mix_t want;
            if (expected_mix_q.size() == 0) begin
                $display("%0t: mix result with none pending, actual left %0d right %0d",
                         $time, $signed(tdata[15:0]), $signed(tdata[31:16]));
                errors++;
                return;
            end
            want = expected_mix_q.pop_front();
            if (tdata[15:0] !== want.left) begin
                $display("%0t: left_sample expected %0d actual %0d",
                         $time, $signed(want.left), $signed(tdata[15:0]));
                errors++;
            end
            if (tdata[31:16] !== want.right) begin
                $display("%0t: right_sample expected %0d actual %0d",
                         $time, $signed(want.right), $signed(tdata[31:16]));
                errors++;
            end
            if (tdata[32] !== want.left_clip) begin
                $display("%0t: left_clipped expected %0b actual %0b",
                         $time, want.left_clip, tdata[32]);
                errors++;
            end
            if (tdata[33] !== want.right_clip) begin
                $display("%0t: right_clipped expected %0b actual %0b",
                         $time, want.right_clip, tdata[33]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // operation, address, data
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // left, right, left_clipped, right_clipped

    tone_mix_scoreboard sb = new();

    int burst_left = 0;
    int served     = 0;

    multi_voice_tone_generator_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Send one request, with a random gap ahead of each burst
    task automatic send_req(input logic [1:0] op, input logic [7:0] addr,
                            input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 5);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, data, addr, op};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        sb.note_request(op, addr, data);
        if (op != OP_UNUSED && !(op == OP_WRITE && addr[7:3] >= N_VOICES)) served++;
    endtask

    task automatic write_reg(input logic [4:0] v, input logic [2:0] sel,
                             input logic [7:0] data);
        send_req(OP_WRITE, {v, sel}, data);
    endtask

    task automatic set_voice(input logic [4:0] v, input logic [15:0] stepv,
                             input logic [7:0] lv, input logic [7:0] rv,
                             input logic [2:0] sh);
        write_reg(v, REG_STEP_LO, stepv[7:0]);
        write_reg(v, REG_STEP_HI, stepv[15:8]);
        write_reg(v, REG_LVOL_HOLD, lv);
        write_reg(v, REG_VOLUME, rv);
        write_reg(v, REG_SHAPE, {5'($urandom), sh});
    endtask

    // Hold off new requests until every tick result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] pick_volume();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'($urandom_range(1, 15));
            2:       return 8'($urandom);
            default: return 8'hFF;
        endcase
    endfunction

    // Result side: check accepted results, stall in stretches of varying density
    initial begin
        int stretch_left;
        int ready_pct;
        m_tready <= 1'b0;
        stretch_left = 0;
        ready_pct    = 100;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) sb.check_mix(m_tdata);
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 30;
                    default: ready_pct = 5;
                endcase
            end
            stretch_left--;
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Request side
    initial begin
        logic [15:0] stepv;
        logic [4:0]  v;
        int          pick;
        bit          paused;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        paused   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: silent tick, loud triangle, loud noise, ignored requests, phase clear, mute
        send_req(OP_TICK, 8'h00, 8'h00);
        set_voice(5'd0, 16'hFEFF, 8'hFF, 8'hFF, WAVE_TRI);
        set_voice(5'd7, 16'hFFFF, 8'hFF, 8'h01, WAVE_SAW_UP);
        send_req(OP_UNUSED, 8'hFF, 8'hFF);
        write_reg(5'd31, REG_VOLUME, 8'hFF);
        write_reg(5'd1, REG_SPARE0, 8'hFF);
        send_req(OP_TICK, 8'hFF, 8'hFF);
        send_req(OP_TICK, 8'h5A, 8'hA5);
        // both volumes zero clears the phase
        write_reg(5'd0, REG_LVOL_HOLD, 8'h00);
        write_reg(5'd0, REG_VOLUME, 8'h00);
        send_req(OP_TICK, 8'h00, 8'h00);
        send_req(OP_MUTE, 8'hFF, 8'hFF);
        send_req(OP_TICK, 8'h00, 8'h00);
        wait_drained();

        // Random: voice setups with random content, ticks, stray writes, noise
        while (served < 1900) begin
            if (!paused && served >= 950) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            v    = 5'($urandom_range(0, N_VOICES - 1));
            if (pick < 12) begin
                case ($urandom_range(0, 3))
                    0:       stepv = {8'hFF, 8'($urandom)};
                    1:       stepv = 16'($urandom_range(1, 'h400));
                    2:       stepv = 16'($urandom);
                    default: stepv = 16'($urandom_range('h1000, 'h3000));
                endcase
                set_voice(v, stepv, pick_volume(), pick_volume(), 3'($urandom));
            end else if (pick < 20) begin
                write_reg(v, 3'($urandom), 8'($urandom));
            end else if (pick < 22) begin
                write_reg(v, REG_LVOL_HOLD, 8'h00);
                write_reg(v, REG_VOLUME, 8'h00);
            end else if (pick < 24) begin
                write_reg(v, ($urandom_range(0, 1) == 0) ? REG_SPARE1 : REG_SPARE2,
                          8'($urandom));
            end else if (pick < 28) begin
                send_req(2'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_req(OP_TICK, 8'($urandom), 8'($urandom));
            end
        end

        wait_drained();
        repeat (N_VOICES + 16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("multi_voice_tone_generator_top: match");
        end else begin
            $display("multi_voice_tone_generator_top: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("multi_voice_tone_generator_top: mismatch");
        $finish;
    end

endmodule
